### hw/rtl/bmp_pkg.sv
`timescale 1ns / 1ps
package bmp_pkg;

  // Modulus and its Barrett reciprocal floor(2^60 / P).
  localparam logic [29:0] PRIME = 30'd1000000007;
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

  // Fermat exponent P-2, scanned LSB first.
  localparam int EXP_BITS = 30;
  localparam logic [EXP_BITS-1:0] EXP_VAL = 30'd1000000005;

  typedef struct packed {
    logic [15:0] n;
    logic [15:0] m;
  } in_item_t;

  typedef struct packed {
    logic signed [30:0] value;
    logic               range_error;
  } out_item_t;

  typedef enum logic [3:0] {
    S_FILL0,
    S_FILL_ISSUE,
    S_FILL_WAIT,
    S_IDLE,
    S_CHECK,
    S_RD_M,
    S_RD_T,
    S_LAT_C,
    S_DEN_WAIT,
    S_EXP_ACC,
    S_EXP_SQR,
    S_EXP_WAIT,
    S_FIN,
    S_FIN_WAIT,
    S_DONE
  } state_t;

  // Operand pairs for the modular multiplier.
  typedef enum logic [2:0] {
    OP_FILL,
    OP_DEN,
    OP_SQR,
    OP_ACC,
    OP_FIN
  } mul_op_t;

  // Where a multiplier result lands.
  typedef enum logic [1:0] {
    DST_FACT,
    DST_BASE,
    DST_ACC
  } mul_dst_t;

  // Table read address source.
  typedef enum logic [1:0] {
    RD_N,
    RD_M,
    RD_T
  } rd_sel_t;

  typedef struct packed {
    logic    fill_init;
    logic    fill_next;
    logic    mul_issue;
    mul_op_t mul_op;
    logic    load_query;
    rd_sel_t rd_sel;
    logic    lat_a;
    logic    lat_b;
    logic    lat_c;
    logic    exp_init;
    logic    set_range;
    logic    set_value;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic out_free;
    logic mul_busy;
    logic range_err;
  } ctrl_status_t;

endpackage

### hw/rtl/binomial_mod_prime.sv
`timescale 1ns / 1ps
// Reset (rst_n low, synchronous) restarts the factorial fill, one three-stage modular
// multiply per entry, with in_ready low throughout.
// A query's time from transfer to result is set by the 30 rounds of the Fermat
// exponent loop through the shared Barrett multiplier.
// A query whose n+m+2 is beyond the table skips the loop and answers with range_error set.
// One query is worked at a time, so a new query is taken only once the last result is
// loaded; a finished result waits in the output register.
module binomial_mod_prime #(
  parameter int TABLE_DEPTH = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bmp_pkg::out_item_t out_data
);
  import bmp_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequencer for the fill sweep and the query steps.
  bmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Table, working registers, multiplier and output register.
  bmp_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/bmp_modmul.sv
`timescale 1ns / 1ps
module bmp_modmul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [29:0]       op_a,
  input  logic [29:0]       op_b,
  input  bmp_pkg::mul_dst_t in_dst,
  output logic              res_valid,
  output bmp_pkg::mul_dst_t res_dst,
  output logic [29:0]       res,
  output logic              busy
);
  import bmp_pkg::*;

  logic        v1_r, v2_r, v3_r;
  mul_dst_t    d1_r, d2_r, d3_r;
  logic [59:0] x_r;
  logic [61:0] qm_r;
  logic [31:0] x2_r, x3_r;
  logic [31:0] qp_r;
  logic [60:0] qp_full;
  logic [31:0] r_raw;
  logic [31:0] p32, p2x32;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 1: full product; stage 2: quotient estimate; stage 3: quotient times P.
  assign qp_full = 61'(qm_r[61:31]) * 61'(PRIME);

  always_ff @(posedge clk) begin
    d1_r <= in_dst;
    x_r  <= 60'(op_a) * 60'(op_b);
    d2_r <= d1_r;
    qm_r <= 62'(x_r[59:29]) * 62'(BARRETT_MU);
    x2_r <= x_r[31:0];
    d3_r <= d2_r;
    qp_r <= qp_full[31:0];
    x3_r <= x2_r;
  end

  // The Barrett remainder is below 3P, so at most two subtractions of P remain.
  assign p32   = 32'(PRIME);
  assign p2x32 = 32'({PRIME, 1'b0});
  assign r_raw = x3_r - qp_r;

  always_comb begin
    if (r_raw >= p2x32) begin
      res = 30'(r_raw - p2x32);
    end else if (r_raw >= p32) begin
      res = 30'(r_raw - p32);
    end else begin
      res = r_raw[29:0];
    end
  end

  assign res_valid = v3_r;
  assign res_dst   = d3_r;
  assign busy      = v1_r | v2_r | v3_r;

endmodule

### hw/rtl/bmp_datapath.sv
`timescale 1ns / 1ps
module bmp_datapath #(
  parameter int TABLE_DEPTH = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bmp_pkg::ctrl_cmd_t    cmd,
  output bmp_pkg::ctrl_status_t status,
  input  bmp_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bmp_pkg::out_item_t    out_data
);
  import bmp_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  // Factorial table and its registered read.
  logic [29:0]       fact_mem [TABLE_DEPTH];
  logic [29:0]       rd_q_r;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [29:0]       wr_data;
  logic              wr_en;

  logic [ADDR_W-1:0] fill_idx_r;
  logic [29:0]       prev_r;
  logic [15:0]       n_r, m_r;
  logic [17:0]       total_r;
  logic [31:0]       n_p1, m_p1, total32;
  logic [29:0]       a_r, b_r, c_r, base_r, acc_r;
  out_item_t         res_r, out_data_r;
  logic              out_valid_r;

  logic [29:0]       mm_a, mm_b;
  mul_dst_t          mm_dst;
  logic              mm_valid;
  mul_dst_t          mm_res_dst;
  logic [29:0]       mm_res;
  logic              mm_busy;

  // Operand selection for the multiplier.
  always_comb begin
    mm_a   = prev_r;
    mm_b   = 30'(fill_idx_r);
    mm_dst = DST_FACT;
    unique case (cmd.mul_op)
      OP_FILL: begin
        mm_a   = prev_r;
        mm_b   = 30'(fill_idx_r);
        mm_dst = DST_FACT;
      end
      OP_DEN: begin
        mm_a   = a_r;
        mm_b   = b_r;
        mm_dst = DST_BASE;
      end
      OP_SQR: begin
        mm_a   = base_r;
        mm_b   = base_r;
        mm_dst = DST_BASE;
      end
      OP_ACC: begin
        mm_a   = acc_r;
        mm_b   = base_r;
        mm_dst = DST_ACC;
      end
      OP_FIN: begin
        mm_a   = acc_r;
        mm_b   = c_r;
        mm_dst = DST_ACC;
      end
      default: begin
        mm_a   = prev_r;
        mm_b   = 30'(fill_idx_r);
        mm_dst = DST_FACT;
      end
    endcase
  end

  bmp_modmul u_modmul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.mul_issue),
    .op_a      (mm_a),
    .op_b      (mm_b),
    .in_dst    (mm_dst),
    .res_valid (mm_valid),
    .res_dst   (mm_res_dst),
    .res       (mm_res)
    ,.busy     (mm_busy)
  );

  // Query indexes, widened so any table depth can be addressed.
  assign n_p1    = 32'(n_r) + 32'd1;
  assign m_p1    = 32'(m_r) + 32'd1;
  assign total32 = 32'(total_r);

  always_comb begin
    case (cmd.rd_sel)
      RD_N:    rd_addr = n_p1[ADDR_W-1:0];
      RD_M:    rd_addr = m_p1[ADDR_W-1:0];
      RD_T:    rd_addr = total32[ADDR_W-1:0];
      default: rd_addr = total32[ADDR_W-1:0];
    endcase
  end

  // Table writes come from the fill start or from fill products.
  assign wr_en   = cmd.fill_init | (mm_valid && (mm_res_dst == DST_FACT));
  assign wr_addr = cmd.fill_init ? '0 : fill_idx_r;
  assign wr_data = cmd.fill_init ? 30'd1 : mm_res;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fact_mem[wr_addr] <= wr_data;
    end
    rd_q_r <= fact_mem[rd_addr];
  end

  // Fill sweep index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_idx_r <= '0;
    end else if (cmd.fill_init) begin
      fill_idx_r <= ADDR_W'(1);
    end else if (cmd.fill_next) begin
      fill_idx_r <= fill_idx_r + ADDR_W'(1);
    end
  end

  // Working registers of the query and the exponent loop.
  always_ff @(posedge clk) begin
    if (cmd.fill_init) begin
      prev_r <= 30'd1;
    end else if (mm_valid && (mm_res_dst == DST_FACT)) begin
      prev_r <= mm_res;
    end
    if (cmd.load_query) begin
      n_r     <= in_data.n;
      m_r     <= in_data.m;
      total_r <= 18'(in_data.n) + 18'(in_data.m) + 18'd2;
    end
    if (cmd.lat_a) begin
      a_r <= rd_q_r;
    end
    if (cmd.lat_b) begin
      b_r <= rd_q_r;
    end
    if (cmd.lat_c) begin
      c_r <= rd_q_r;
    end
    if (mm_valid && (mm_res_dst == DST_BASE)) begin
      base_r <= mm_res;
    end
    if (cmd.exp_init) begin
      acc_r <= 30'd1;
    end else if (mm_valid && (mm_res_dst == DST_ACC)) begin
      acc_r <= mm_res;
    end
    if (cmd.set_range) begin
      res_r.value       <= '0;
      res_r.range_error <= 1'b1;
    end else if (cmd.set_value) begin
      res_r.value       <= $signed(31'(acc_r) - 31'd1);
      res_r.range_error <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  // Output register; a result waits here until transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status back to the controller.
  always_comb begin
    status.fill_last = (fill_idx_r == ADDR_W'(TABLE_DEPTH - 1));
    status.out_free  = !out_valid_r || out_ready;
    status.mul_busy  = mm_busy;
    status.range_err = (total32 >= 32'(TABLE_DEPTH));
  end

endmodule

### hw/rtl/bmp_ctrl.sv
`timescale 1ns / 1ps
module bmp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bmp_pkg::ctrl_status_t status,
  output bmp_pkg::ctrl_cmd_t    cmd
);
  import bmp_pkg::*;

  state_t     state_r, state_nxt;
  logic [4:0] bit_idx_r, bit_idx_nxt;

  // State and exponent bit counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_FILL0;
      bit_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_idx_r <= bit_idx_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    bit_idx_nxt = bit_idx_r;
    cmd         = '0;
    cmd.mul_op  = OP_FILL;
    cmd.rd_sel  = RD_N;
    in_ready    = 1'b0;
    unique case (state_r)
      S_FILL0: begin
        cmd.fill_init = 1'b1;
        state_nxt     = S_FILL_ISSUE;
      end
      S_FILL_ISSUE: begin
        cmd.mul_issue = 1'b1;
        cmd.mul_op    = OP_FILL;
        state_nxt     = S_FILL_WAIT;
      end
      S_FILL_WAIT: begin
        if (!status.mul_busy) begin
          if (status.fill_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.fill_next = 1'b1;
            state_nxt     = S_FILL_ISSUE;
          end
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_query = 1'b1;
          state_nxt      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.range_err) begin
          cmd.set_range = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.rd_sel = RD_N;
          state_nxt  = S_RD_M;
        end
      end
      S_RD_M: begin
        cmd.rd_sel = RD_M;
        cmd.lat_a  = 1'b1;
        state_nxt  = S_RD_T;
      end
      S_RD_T: begin
        cmd.rd_sel = RD_T;
        cmd.lat_b  = 1'b1;
        state_nxt  = S_LAT_C;
      end
      S_LAT_C: begin
        cmd.lat_c     = 1'b1;
        cmd.mul_issue = 1'b1;
        cmd.mul_op    = OP_DEN;
        cmd.exp_init  = 1'b1;
        bit_idx_nxt   = '0;
        state_nxt     = S_DEN_WAIT;
      end
      S_DEN_WAIT: begin
        if (!status.mul_busy) begin
          state_nxt = S_EXP_ACC;
        end
      end
      // Both products of a round read the old base, so they issue back to back.
      S_EXP_ACC: begin
        if (EXP_VAL[bit_idx_r]) begin
          cmd.mul_issue = 1'b1;
          cmd.mul_op    = OP_ACC;
        end
        state_nxt = S_EXP_SQR;
      end
      S_EXP_SQR: begin
        cmd.mul_issue = 1'b1;
        cmd.mul_op    = OP_SQR;
        state_nxt     = S_EXP_WAIT;
      end
      S_EXP_WAIT: begin
        if (!status.mul_busy) begin
          if (bit_idx_r == 5'(EXP_BITS - 1)) begin
            state_nxt = S_FIN;
          end else begin
            bit_idx_nxt = bit_idx_r + 5'd1;
            state_nxt   = S_EXP_ACC;
          end
        end
      end
      S_FIN: begin
        cmd.mul_issue = 1'b1;
        cmd.mul_op    = OP_FIN;
        state_nxt     = S_FIN_WAIT;
      end
      S_FIN_WAIT: begin
        if (!status.mul_busy) begin
          cmd.set_value = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_FILL0;
      end
    endcase
  end

endmodule

### tb/sv/tb_binomial_mod_prime.sv
`timescale 1ns / 1ps
module tb_binomial_mod_prime;
  import bmp_pkg::*;

  localparam int TABLE_DEPTH = 65536;
  localparam logic [63:0] MODULUS = 64'(PRIME);
  localparam int CYCLE_LIMIT = 6000000;
  localparam int DRAIN_CYCLES = 250;
  localparam int LONG_HOLD = 3000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Factorials k! mod P, the testbench's own copy of the table.
  logic [29:0] fact_mod [TABLE_DEPTH];
  out_item_t   expected_results [$];
  int          errors = 0;
  int          cycle_count = 0;
  int          hold_request = 0;
  bit          no_idle = 1'b0;

  binomial_mod_prime #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Product of two residues, reduced modulo P.
  function automatic logic [29:0] mul_mod(input logic [29:0] a, input logic [29:0] b);
    logic [63:0] prod;
    prod = {34'd0, a} * {34'd0, b};
    return 30'(prod % MODULUS);
  endfunction

  // Inverse by Fermat: a^(P-2) mod P, square-and-multiply from the LSB.
  function automatic logic [29:0] fermat_inverse(input logic [29:0] a);
    logic [29:0] acc;
    logic [29:0] base;
    logic [29:0] e;
    acc  = 30'd1;
    base = a;
    e    = EXP_VAL;
    while (e != 30'd0) begin
      if (e[0]) acc = mul_mod(acc, base);
      base = mul_mod(base, base);
      e    = e >> 1;
    end
    return acc;
  endfunction

  // Expected answer: C(n+m+2, n+1) mod P minus one, or a range flag.
  function automatic out_item_t predict_binomial(input in_item_t q);
    out_item_t   r;
    int          total;
    logic [29:0] denom;
    logic [29:0] binom;
    total         = int'(q.n) + int'(q.m) + 2;
    r.value       = '0;
    r.range_error = 1'b1;
    if (total < TABLE_DEPTH) begin
      denom         = mul_mod(fact_mod[int'(q.n) + 1], fact_mod[int'(q.m) + 1]);
      binom         = mul_mod(fermat_inverse(denom), fact_mod[total]);
      r.value       = 31'({1'b0, binom} - 31'd1);
      r.range_error = 1'b0;
    end
    return r;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 300);
  endfunction

  // Offer one query and hold it until the transfer, then maybe idle.
  task automatic send_query(input logic [15:0] n, input logic [15:0] m);
    int gap;
    in_data  <= '{n: n, m: m};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering after the last transfer of a burst.
  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Mostly sums inside the table, some small, some fully random.
  task automatic send_random_query();
    logic [15:0] n;
    logic [15:0] m;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      n = 16'($urandom);
      m = 16'($urandom);
    end else if (r < 30) begin
      n = 16'($urandom_range(0, 63));
      m = 16'($urandom_range(0, 63));
    end else begin
      n = 16'($urandom_range(0, 65533));
      m = 16'($urandom_range(0, 65533 - int'(n)));
    end
    send_query(n, m);
  endtask

  // Queries offered right after reset wait out the factorial sweep.
  task automatic test_query_during_fill();
    send_query(16'd0, 16'd0);
    send_query(16'd3, 16'd4);
  endtask

  // Field extremes, the largest sum in the table and sums just past it.
  task automatic test_corner_queries();
    send_query(16'd1, 16'd0);
    send_query(16'd0, 16'd1);
    send_query(16'd1, 16'd1);
    send_query(16'd65533, 16'd0);
    send_query(16'd0, 16'd65533);
    send_query(16'd32766, 16'd32767);
    send_query(16'd65534, 16'd0);
    send_query(16'd0, 16'd65534);
    send_query(16'd32767, 16'd32767);
    send_query(16'd65535, 16'd65535);
    send_query(16'd65535, 16'd0);
    send_query(16'd0, 16'd65535);
    send_query(16'h5555, 16'h2AAA);
    send_query(16'h2AAA, 16'h5555);
    send_query(16'hAAAA, 16'h5555);
    send_query(16'd100, 16'd200);
  endtask

  // Receiver holds off long enough that the block fills and stalls its input.
  task automatic test_full_input_stall();
    hold_request = LONG_HOLD;
    no_idle      = 1'b1;
    repeat (8) send_random_query();
    no_idle = 1'b0;
    end_burst();
    wait_for_results();
  endtask

  // Sender pauses until every outstanding result has come back.
  task automatic test_pause_until_drained();
    repeat (3) begin
      repeat (5) send_random_query();
      end_burst();
      wait_for_results();
    end
  endtask

  // A stretch with no idling on either side.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (150) send_random_query();
    no_idle = 1'b0;
  endtask

  task automatic test_random_queries(input int count);
    repeat (count) send_random_query();
  endtask

  // Receiver: random ready pattern, with a long hold when one is requested.
  initial begin : receiver
    int len;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        len          = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (len) @(posedge clk);
      end else begin
        len = idle_cycles();
        if (len > 0) begin
          out_ready <= 1'b0;
          repeat (len) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Each input transfer queues its predicted result.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) expected_results.push_back(predict_binomial(in_data));
  end

  // Each output transfer is compared with the oldest prediction.
  always @(posedge clk) begin : check_result
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: value %0d, range_error %0b",
               $signed(out_data.value), out_data.range_error);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.value !== want.value) begin
          $error("value: expected %0d, actual %0d", $signed(want.value),
                 $signed(out_data.value));
          errors++;
        end
        if (out_data.range_error !== want.range_error) begin
          $error("range_error: expected %0b, actual %0b", want.range_error,
                 out_data.range_error);
          errors++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("binomial_mod_prime test failed");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    fact_mod[0] = 30'd1;
    for (int k = 1; k < TABLE_DEPTH; k++) fact_mod[k] = mul_mod(30'(k), fact_mod[k-1]);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_query_during_fill();
    test_corner_queries();
    test_full_input_stall();
    test_pause_until_drained();
    test_back_to_back();
    test_random_queries(1700);
    end_burst();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("binomial_mod_prime test passed");
    end else begin
      $display("binomial_mod_prime test failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/bmp_pkg.sv
hw/rtl/bmp_modmul.sv
hw/rtl/bmp_datapath.sv
hw/rtl/bmp_ctrl.sv
hw/rtl/binomial_mod_prime.sv
tb/sv/tb_binomial_mod_prime.sv
